/* rtl/csu_pkg.sv */
// Shared types and constants of the cosine similarity unit.
package csu_pkg;

	localparam int ACC_W       = 44;
	localparam int RES_W       = 32;
	localparam int Q_FRAC      = 30;
	localparam int PROD_W      = 2 * ACC_W;
	localparam int ROOT_REM_W  = ACC_W + 1;
	localparam int STEP_W      = $clog2(ACC_W);
	localparam int QUEUE_DEPTH = 2;

	localparam logic signed [ACC_W-1:0] ACC_SMAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_SMIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic        [ACC_W-1:0] ACC_UMAX = {ACC_W{1'b1}};
	localparam logic signed [RES_W-1:0] ONE_Q30  = RES_W'(1) << Q_FRAC;

	// Finished sums of one pair of vectors, handed from the front to the back.
	typedef struct packed {
		logic signed [ACC_W-1:0] dot;
		logic        [ACC_W-1:0] sum_a;
		logic        [ACC_W-1:0] sum_b;
		logic                    too_long;
	} csu_job_t;

endpackage

/* rtl/csu_pair_if.sv */
// Input channel: one element pair per word.
interface csu_pair_if #(parameter int DATA_WIDTH = 16);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] element_a;
	logic signed [DATA_WIDTH-1:0] element_b;
	logic                         last_pair;

	modport source(output valid, element_a, element_b, last_pair, input ready);
	modport sink(input valid, element_a, element_b, last_pair, output ready);
endinterface

/* rtl/csu_result_if.sv */
// Output channel: one similarity result per word.
interface csu_result_if;
	logic                    valid;
	logic                    ready;
	logic signed [31:0]      similarity;
	logic                    zero_magnitude;
	logic                    too_long;

	modport source(output valid, similarity, zero_magnitude, too_long, input ready);
	modport sink(input valid, similarity, zero_magnitude, too_long, output ready);
endinterface

/* rtl/csu_front.sv */
// Front: product stage and saturating sums, one pair per cycle unless stalled.
module csu_front #(
	parameter int MAX_LEN    = 4096,
	parameter int DATA_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	csu_pair_if.sink          pairs,
	output csu_pkg::csu_job_t job,
	output logic              job_valid,
	input  logic              job_ready
);

	localparam int PW    = 2 * DATA_WIDTH;
	localparam int SUM_W = ((PW > csu_pkg::ACC_W) ? PW : csu_pkg::ACC_W) + 1;
	localparam int CNT_W = $clog2(MAX_LEN + 1);

	logic                             valid_s1;
	logic                             last_s1;
	logic signed [PW-1:0]             ab_s1;
	logic signed [PW-1:0]             aa_s1;
	logic signed [PW-1:0]             bb_s1;

	logic signed [csu_pkg::ACC_W-1:0] dot_q;
	logic        [csu_pkg::ACC_W-1:0] sum_a_q;
	logic        [csu_pkg::ACC_W-1:0] sum_b_q;
	logic        [CNT_W-1:0]          count_q;
	logic                             ovf_q;

	logic signed [SUM_W-1:0]          dot_w;
	logic        [SUM_W-1:0]          sa_w;
	logic        [SUM_W-1:0]          sb_w;
	logic signed [csu_pkg::ACC_W-1:0] dot_nx;
	logic        [csu_pkg::ACC_W-1:0] sa_nx;
	logic        [csu_pkg::ACC_W-1:0] sb_nx;
	logic        [CNT_W-1:0]          count_nx;
	logic                             ovf_nx;
	logic                             at_max;
	logic                             advance;
	logic                             take;

	// Hold the product stage only when a finished vector cannot enter the queue.
	assign advance     = !valid_s1 || !last_s1 || job_ready;
	assign take        = valid_s1 && advance;
	assign pairs.ready = advance;
	assign job_valid   = valid_s1 && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= pairs.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pairs.valid) begin
			last_s1 <= pairs.last_pair;
			ab_s1   <= PW'(pairs.element_a) * PW'(pairs.element_b);
			aa_s1   <= PW'(pairs.element_a) * PW'(pairs.element_a);
			bb_s1   <= PW'(pairs.element_b) * PW'(pairs.element_b);
		end
	end

	always_comb begin
		at_max   = (count_q == CNT_W'(MAX_LEN));
		ovf_nx   = ovf_q || at_max;
		count_nx = at_max ? count_q : count_q + CNT_W'(1);

		dot_w = SUM_W'(dot_q) + SUM_W'(ab_s1);
		if (dot_w > SUM_W'(csu_pkg::ACC_SMAX)) begin
			dot_nx = csu_pkg::ACC_SMAX;
		end else if (dot_w < SUM_W'(csu_pkg::ACC_SMIN)) begin
			dot_nx = csu_pkg::ACC_SMIN;
		end else begin
			dot_nx = csu_pkg::ACC_W'(dot_w);
		end

		sa_w  = SUM_W'(sum_a_q) + SUM_W'(aa_s1);
		sa_nx = (sa_w > SUM_W'(csu_pkg::ACC_UMAX)) ? csu_pkg::ACC_UMAX
		                                           : csu_pkg::ACC_W'(sa_w);
		sb_w  = SUM_W'(sum_b_q) + SUM_W'(bb_s1);
		sb_nx = (sb_w > SUM_W'(csu_pkg::ACC_UMAX)) ? csu_pkg::ACC_UMAX
		                                           : csu_pkg::ACC_W'(sb_w);
	end

	assign job.dot      = dot_nx;
	assign job.sum_a    = sa_nx;
	assign job.sum_b    = sb_nx;
	assign job.too_long = ovf_nx;

	// Clear the accumulators once the last pair has left with its vector.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q   <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			if (last_s1) begin
				dot_q   <= '0;
				sum_a_q <= '0;
				sum_b_q <= '0;
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				dot_q   <= dot_nx;
				sum_a_q <= sa_nx;
				sum_b_q <= sb_nx;
				count_q <= count_nx;
				ovf_q   <= ovf_nx;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_LEN))
		else $error("pair count beyond maximum length");

	a_ovf_at_max: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> at_max)
		else $error("overflow flag set below maximum length");

endmodule

/* rtl/csu_queue.sv */
// Two-word queue that decouples the accumulators from the root and divide unit.
module csu_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  csu_pkg::csu_job_t push_job,
	input  logic              push_valid,
	output logic              push_ready,
	output csu_pkg::csu_job_t pop_job,
	output logic              pop_valid,
	input  logic              pop_ready
);

	localparam int PTR_W = $clog2(csu_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(csu_pkg::QUEUE_DEPTH + 1);

	csu_pkg::csu_job_t mem_q [csu_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != CNT_W'(csu_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_job    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(csu_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(csu_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_depth: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(csu_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

/* rtl/csu_back.sv */
// Back end: serial multiply, bitwise square root and restoring divide, then output register.
module csu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  csu_pkg::csu_job_t job,
	input  logic              job_valid,
	output logic              job_ready,
	csu_result_if.source      results
);

	localparam int AW = csu_pkg::ACC_W;
	localparam int SW = csu_pkg::STEP_W;
	localparam int RW = csu_pkg::ROOT_REM_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ROOT = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]                        state_q;
	logic [SW-1:0]                     step_q;
	logic                              neg_q;
	logic                              zero_q;
	logic                              long_q;
	logic [AW-1:0]                     mag_q;
	logic [AW-1:0]                     sum_a_q;
	logic [csu_pkg::PROD_W-1:0]        prod_q;
	logic [RW-1:0]                     rem_q;
	logic [AW-1:0]                     root_q;
	logic [csu_pkg::Q_FRAC-1:0]        quo_q;

	logic                              out_valid_q;
	logic signed [csu_pkg::RES_W-1:0]  sim_q;
	logic                              zero_out_q;
	logic                              long_out_q;

	logic [AW:0]                       mul_sum;
	logic [RW+1:0]                     rem_sh;
	logic [RW+1:0]                     trial;
	logic [RW-1:0]                     div_sh;
	logic                              root_fit;
	logic                              div_fit;
	logic                              saturate;
	logic [csu_pkg::RES_W-1:0]         mag_res;
	logic signed [csu_pkg::RES_W-1:0]  sim_nx;
	logic                              out_free;

	assign job_ready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || results.ready;

	always_comb begin
		mul_sum  = {1'b0, prod_q[csu_pkg::PROD_W-1:AW]}
		         + (prod_q[0] ? {1'b0, sum_a_q} : '0);
		rem_sh   = {rem_q, prod_q[csu_pkg::PROD_W-1 -: 2]};
		trial    = {1'b0, root_q, 2'b01};
		root_fit = (rem_sh >= trial);
		div_sh   = {rem_q[AW-1:0], 1'b0};
		div_fit  = (div_sh >= {1'b0, root_q});
		saturate = (mag_q >= root_q);
		mag_res  = saturate ? csu_pkg::ONE_Q30 : csu_pkg::RES_W'(quo_q);
		if (zero_q) begin
			sim_nx = '0;
		end else begin
			sim_nx = neg_q ? -$signed(mag_res) : $signed(mag_res);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						step_q  <= '0;
						state_q <= (job.sum_a == '0 || job.sum_b == '0) ? ST_DONE : ST_MUL;
					end
				end
				ST_MUL: begin
					step_q <= (step_q == SW'(AW - 1)) ? '0 : step_q + SW'(1);
					if (step_q == SW'(AW - 1)) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					step_q <= (step_q == SW'(AW - 1)) ? '0 : step_q + SW'(1);
					if (step_q == SW'(AW - 1)) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + SW'(1);
					if (step_q == SW'(csu_pkg::Q_FRAC)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					neg_q   <= job.dot[AW-1];
					mag_q   <= job.dot[AW-1] ? AW'(-job.dot) : AW'(job.dot);
					zero_q  <= (job.sum_a == '0 || job.sum_b == '0);
					long_q  <= job.too_long;
					sum_a_q <= job.sum_a;
					prod_q  <= {{AW{1'b0}}, job.sum_b};
				end
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_MUL: begin
				// Shift-and-add: one multiplier bit per step, product grows from the top.
				prod_q <= {mul_sum, prod_q[AW-1:1]};
			end
			ST_ROOT: begin
				// Bring down two product bits and try the next root bit.
				prod_q <= {prod_q[csu_pkg::PROD_W-3:0], 2'b00};
				root_q <= {root_q[AW-2:0], root_fit};
				rem_q  <= root_fit ? RW'(rem_sh - trial) : RW'(rem_sh);
				if (step_q == SW'(AW - 1)) begin
					quo_q <= '0;
				end
			end
			ST_DIV: begin
				if (step_q == '0) begin
					rem_q <= {1'b0, mag_q};
				end else begin
					rem_q <= div_fit ? div_sh - {1'b0, root_q} : div_sh;
					quo_q <= {quo_q[csu_pkg::Q_FRAC-2:0], div_fit};
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Output register: a result waits here while the next vector is fetched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			sim_q      <= sim_nx;
			zero_out_q <= zero_q;
			long_out_q <= long_q;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.similarity     = sim_q;
	assign results.zero_magnitude = zero_out_q;
	assign results.too_long       = long_out_q;

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && zero_out_q |-> sim_q == '0)
		else $error("zero magnitude with nonzero similarity");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (sim_q <= csu_pkg::ONE_Q30) && (sim_q >= -csu_pkg::ONE_Q30))
		else $error("similarity outside minus one to one");

	a_busy_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !job_ready)
		else $error("queue popped while back end busy");

endmodule

/* rtl/cosine_similarity_unit.sv */
// Top level of the cosine similarity unit.
// Two vectors stream in as element pairs, one word per cycle at full rate; the pair
// with last_pair set closes the vectors, and one result word later carries
// dot / sqrt(sum_a * sum_b) in signed Q2.30, truncated toward zero and clamped to
// plus or minus one. The front end registers the three products and updates the
// saturating 44-bit accumulators, so pairs and vectors may follow each other with
// no gap while the queue has room. Finished sums go through a two-word queue to the
// back end, which runs a shift-and-add multiply of the two sums of squares, a
// bitwise square root of the 88-bit product and a restoring divide, with a state
// each to fetch and to finish, one vector at a time. With vectors shorter than the
// back end's run the queue fills and the input stalls; longer vectors hide the back
// end completely. A zero sum of squares skips the arithmetic: the result is 0 with
// zero_magnitude set. Vectors longer than MAX_LEN pairs set too_long, and their
// sums keep saturating. Elements are DATA_WIDTH-bit two's complement; the pairs
// channel is built with the same DATA_WIDTH.
module cosine_similarity_unit #(
	parameter int MAX_LEN    = 4096,
	parameter int DATA_WIDTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	csu_pair_if.sink     pairs,
	csu_result_if.source results
);

	csu_pkg::csu_job_t front_job;
	logic              front_valid;
	logic              front_ready;
	csu_pkg::csu_job_t back_job;
	logic              back_valid;
	logic              back_ready;

	// Accumulate pairs; hand over the sums of each closed pair of vectors.
	csu_front #(
		.MAX_LEN    (MAX_LEN),
		.DATA_WIDTH (DATA_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pairs     (pairs),
		.job       (front_job),
		.job_valid (front_valid),
		.job_ready (front_ready)
	);

	// Buffer finished sums; the accumulators wait only while the queue is full.
	csu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_job   (front_job),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_job    (back_job),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	// Multiply, root, divide and sign; drive the result words.
	csu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (back_job),
		.job_valid (back_valid),
		.job_ready (back_ready),
		.results   (results)
	);

endmodule
